### hw/rtl/ctu_pkg.sv
package ctu_pkg;

  // Width of the cycle counter samples and of the microsecond timestamp.
  localparam int unsigned WORD_W = 32;
  // Width of the cycles-per-microsecond divisor and of the kept remainder.
  localparam int unsigned DIV_W = 10;
  // Width of the divider step counter, one step per quotient bit.
  localparam int unsigned STEP_W = $clog2(WORD_W);

  // Divisor that stands in for a programmed value of zero.
  localparam logic [DIV_W-1:0] DIV_ONE = DIV_W'(1);

endpackage

### hw/rtl/ctu_divider.sv
module ctu_divider
  import ctu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              done,
  output logic [WORD_W-1:0] quotient,
  output logic [DIV_W-1:0]  remainder
);

  // Restoring radix-2 divider. The quotient register starts out holding the
  // dividend; each step shifts one dividend bit into the partial remainder
  // and one quotient bit in at the bottom.
  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DIV_W-1:0]  div_reg;
  logic [WORD_W-1:0] quo;
  logic [DIV_W-1:0]  rem;

  logic [DIV_W:0]    rem_trial;
  logic [DIV_W:0]    rem_diff;
  logic              fits;
  logic [DIV_W-1:0]  rem_next;
  logic [WORD_W-1:0] quo_next;

  always_comb begin
    rem_trial = {rem, quo[WORD_W-1]};
    rem_diff  = rem_trial - {1'b0, div_reg};
    fits      = (rem_trial >= {1'b0, div_reg});
    // When the trial does not fit it is below the divisor, so its top bit is zero.
    rem_next  = fits ? rem_diff[DIV_W-1:0] : rem_trial[DIV_W-1:0];
    quo_next  = {quo[WORD_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= dividend;
      rem     <= '0;
      div_reg <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### hw/rtl/cycle_to_microsecond_timestamp_unit.sv
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-------------------------------
// input     | in        | in_valid / in_stall  | cycle_sample [31:0]
// output    | out       | out_valid / out_stall| timestamp_us [31:0]
// config    | in        | cfg_wen              | cfg_wdata [9:0] (cycles_per_us)
//
// Each sample, once transferred, is divided by the restoring divider at one
// quotient bit per cycle; the state is then committed and the output
// register loaded before its timestamp is offered. The input stays stalled
// for the whole conversion.
// A finished timestamp waits in the output register, so the next sample can
// be taken while the previous result is still stalled; a conversion that
// finishes while the output is still full waits until it drains.
// Reset (synchronous, active high) sets the divisor to 72 and clears the
// previous sample, the leftover cycles and the elapsed microsecond count.
module cycle_to_microsecond_timestamp_unit
  import ctu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [DIV_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [WORD_W-1:0] cycle_sample,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] timestamp_us
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_PUT  = 3'b100
  } state_t;

  state_t            state;
  logic [DIV_W-1:0]  cycles_per_us;
  logic [WORD_W-1:0] previous_sample;
  logic [DIV_W-1:0]  leftover_cycles;
  logic [WORD_W-1:0] elapsed_us;

  logic              in_xfer;
  logic              out_free;
  logic [WORD_W-1:0] cycle_sum;
  logic [DIV_W-1:0]  divisor;
  logic              div_done;
  logic [WORD_W-1:0] div_quotient;
  logic [DIV_W-1:0]  div_remainder;

  // The block only takes a sample while no conversion is in flight.
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  // The output register can be loaded when it is empty or drains this cycle.
  assign out_free = !out_valid || !out_stall;

  // The counter difference wraps modulo 2^32, and so does the sum with the
  // leftover, matching unsigned 32-bit arithmetic.
  assign cycle_sum = (cycle_sample - previous_sample) + WORD_W'(leftover_cycles);
  // A programmed divisor of zero behaves as a divisor of one.
  assign divisor   = (cycles_per_us == '0) ? DIV_ONE : cycles_per_us;

  ctu_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (in_xfer),
    .dividend  (cycle_sum),
    .divisor   (divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_us <= DIV_W'(72);
    end else if (cfg_wen) begin
      cycles_per_us <= cfg_wdata;
    end
  end

  // A sum below the divisor gives a zero quotient and the sum itself as the
  // remainder, so the same update covers both cases.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      previous_sample <= '0;
      leftover_cycles <= '0;
      elapsed_us      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            previous_sample <= cycle_sample;
            state           <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            elapsed_us      <= elapsed_us + div_quotient;
            leftover_cycles <= div_remainder;
            state           <= S_PUT;
          end
        end
        S_PUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUT && out_free) begin
      timestamp_us <= elapsed_us;
    end
  end

endmodule

### hw/rtl/ctu_checker.sv
module ctu_checker
  import ctu_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [WORD_W-1:0] cycle_sample,
  input logic              out_valid,
  input logic              out_stall,
  input logic [WORD_W-1:0] timestamp_us
);

  // After reset nothing is pending and the block is ready for a sample.
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output pending or input stalled after reset");

  // A held result keeps its value until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(timestamp_us))
    else $error("stalled timestamp changed or dropped");

  // A conversion keeps the input stalled once a sample is taken.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input taken again during a conversion");

  // No result can appear right after a sample is taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result offered too early");

  // A sample waiting on a stalled input does not change.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> $stable(cycle_sample))
    else $error("stalled cycle sample changed");

endmodule

bind cycle_to_microsecond_timestamp_unit ctu_checker u_ctu_checker (.*);

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ctu_pkg::*;

  // The divisor register comes out of reset holding 72.
  localparam logic [DIV_W-1:0] DIVISOR_AT_RESET = DIV_W'(72);
  // The random part runs in phases, each with its own divisor setting.
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned SAMPLES_PER_PHASE = 43;
  // The long receiver hold-off is far longer than one conversion, so the
  // output register fills, the next conversion waits, and the input stalls.
  localparam int unsigned HOLD_CYCLES = 400;
  // The drain at the end waits longer than one conversion takes.
  localparam int unsigned SETTLE_CYCLES = 50;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wen = 1'b0;
  logic [DIV_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [WORD_W-1:0] cycle_sample = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] timestamp_us;

  cycle_to_microsecond_timestamp_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cycle_sample (cycle_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .timestamp_us (timestamp_us)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Samples waiting to be offered on the input channel, filled by the
  // stimulus process and drained by the driver.
  logic [WORD_W-1:0] pending_samples[$];
  // Timestamps predicted for accepted samples, oldest first.
  logic [WORD_W-1:0] timestamp_expect_q[$];

  // Shadow copy of the converter state and of its divisor register.
  logic [DIV_W-1:0]  active_divisor = DIVISOR_AT_RESET;
  logic [WORD_W-1:0] seen_sample = '0;
  logic [DIV_W-1:0]  carry_cycles = '0;
  logic [WORD_W-1:0] us_count = '0;

  // Random idling and stalling, in percent of cycles. The stimulus process
  // changes these only between phases.
  int unsigned sender_idle_pct = 10;
  int unsigned receiver_stall_pct = 10;

  // Long hold-off of the receiver, requested once by the stimulus process
  // and timed by the receiver itself.
  logic        hold_wanted = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  int unsigned error_count = 0;
  logic        in_taken = 1'b0;
  logic [WORD_W-1:0] next_base = '0;

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Advance the shadow state by one counter sample and return the new
  // timestamp. The difference and the sum both wrap modulo 2^32, and a
  // programmed divisor of zero acts as one.
  function automatic logic [WORD_W-1:0] advance_timestamp(input logic [WORD_W-1:0] sample);
    logic [WORD_W-1:0] divisor;
    logic [WORD_W-1:0] delta;
    logic [WORD_W-1:0] total;
    divisor = (active_divisor == '0) ? WORD_W'(DIV_ONE) : WORD_W'(active_divisor);
    delta = sample - seen_sample;
    seen_sample = sample;
    total = WORD_W'(carry_cycles) + delta;
    if (total >= divisor) begin
      us_count = us_count + total / divisor;
      carry_cycles = DIV_W'(total % divisor);
    end else begin
      carry_cycles = DIV_W'(total);
    end
    return us_count;
  endfunction

  // Pick the next counter sample. Four of nine cases step forward, three by
  // amounts sized against the divisor; others repeat the sample, step just
  // short of a full counter turn, park near the wrap point, or jump anywhere.
  function automatic logic [WORD_W-1:0] pick_sample(input logic [WORD_W-1:0] base);
    int unsigned span;
    span = (active_divisor == '0) ? 1 : int'(active_divisor);
    case ($urandom_range(8))
      0:       return base + $urandom_range(span - 1);
      1:       return base + $urandom_range(4 * span);
      2:       return base + $urandom_range(100000);
      3:       return base + WORD_W'(span) * $urandom_range(16);
      4:       return base;
      5:       return base - WORD_W'($urandom_range(1023, 1));
      6:       return 32'hFFFF_FFFF - $urandom_range(500);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_sample(input logic [WORD_W-1:0] sample);
    pending_samples.push_back(sample);
    next_base = sample;
  endtask

  // The block is idle once nothing is queued, nothing is offered and every
  // predicted timestamp has come out.
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid || timestamp_expect_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_divisor(input logic [DIV_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    active_divisor = value;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Input side, sampling half: a transfer happens at a rising edge with
  // valid high and stall low. Each accepted sample is run through the shadow
  // state right away, so predictions follow the order of acceptance.
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall)
      timestamp_expect_q.push_back(advance_timestamp(cycle_sample));
  end

  // Input side, driving half: at the falling edge, a new sample is offered
  // only if the channel is empty or its last sample was just taken. An
  // offered sample stays put, with valid high, until it is accepted.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        cycle_sample <= pending_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side, receiver: random stalls, plus one long hold-off that keeps
  // its own cycle count.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_wanted && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Output side, monitor: every transfer is matched against the oldest
  // prediction. A result with nothing predicted is an error as well.
  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (timestamp_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected timestamp_us %0d", timestamp_us));
      end else begin
        want = timestamp_expect_q.pop_front();
        if (timestamp_us !== want)
          report_mismatch($sformatf("timestamp_us got %0d, want %0d", timestamp_us, want));
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned k;
    logic [DIV_W-1:0] divisor;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset divisor of 72. The first sample counts in
    // full from a previous sample of zero, then a repeated sample gives a
    // zero difference, a small step keeps the sum below the divisor, and
    // the next one lands exactly on it.
    queue_sample(32'h0000_0100);
    queue_sample(32'h0000_0100);
    queue_sample(32'h0000_0114);
    queue_sample(32'h0000_0120);
    queue_sample(32'h0000_0167);
    // Counter extremes, a wrap past zero, a step backwards that reads as a
    // nearly full counter turn, and alternating bit patterns.
    queue_sample(32'hFFFF_FFFF);
    queue_sample(32'h0000_0005);
    queue_sample(32'h0000_0000);
    queue_sample(32'h8000_0000);
    queue_sample(32'hAAAA_AAAA);
    queue_sample(32'h5555_5555);
    queue_sample(32'h0000_0000);

    // Largest divisor. The first step tops the leftover up to 1022 without
    // crossing the divisor, then a step of 2^32 - 1 makes the sum wrap.
    write_divisor(10'd1023);
    queue_sample(next_base + WORD_W'(10'd1022 - carry_cycles));
    queue_sample(next_base - 1);

    // Lowering the divisor far below the kept leftover: the whole sum is
    // divided at the next step.
    write_divisor(10'd3);
    queue_sample(next_base);
    queue_sample(next_base + 7);

    // A divisor of zero behaves as one, so every cycle is a microsecond.
    write_divisor(10'd0);
    queue_sample(next_base + 5);
    queue_sample(next_base + 32'h1234_5678);

    write_divisor(10'd1);
    queue_sample(next_base + 1);
    queue_sample(next_base);

    // Random part, one divisor per phase with the extremes among them.
    // One phase runs with no idling on either side, and another carries
    // the long receiver hold-off while the sender keeps offering samples.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0, 7:     divisor = 10'd1023;
        1, 9:     divisor = 10'd0;
        3:        divisor = 10'd1;
        4:        divisor = DIVISOR_AT_RESET;
        6:        divisor = 10'd2;
        default:  divisor = DIV_W'($urandom_range(1023, 1));
      endcase
      write_divisor(divisor);
      sender_idle_pct = (phase == 3) ? 0 : 10;
      receiver_stall_pct = (phase == 3) ? 0 : 10;
      if (phase == 6)
        hold_wanted = 1'b1;
      for (k = 0; k < SAMPLES_PER_PHASE; k++)
        queue_sample(pick_sample(next_base));
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("** cycle_to_microsecond_timestamp_unit: PASSED **");
    else
      $display("** cycle_to_microsecond_timestamp_unit: FAILED **");
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this time.
  initial begin
    #3_000_000;
    $display("** cycle_to_microsecond_timestamp_unit: FAILED **");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/ctu_pkg.sv
hw/rtl/ctu_divider.sv
hw/rtl/cycle_to_microsecond_timestamp_unit.sv
hw/rtl/ctu_checker.sv
dv/tb_top.sv
